// ===== hw/rtl/ipd_frame_deframer_defines.svh =====
// Assertion macros shared by the deframer RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef IPD_FRAME_DEFRAMER_DEFINES_SVH
`define IPD_FRAME_DEFRAMER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IPDFD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed in the same cycle");
`define IPDFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed in the next cycle");
`else
`define IPDFD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define IPDFD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/ipdfd_pkg.sv =====
// Types and constants of the frame deframer.
// Depends on nothing; used by ipdfd_parser and ipd_frame_deframer.
package ipdfd_pkg;

    localparam int unsigned LEN_BITS_DEF = 16;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [3:0] {
        PH_PLUS  = 4'd0,
        PH_I     = 4'd1,
        PH_P     = 4'd2,
        PH_D     = 4'd3,
        PH_COMMA = 4'd4,
        PH_LEN   = 4'd5,
        PH_DATA  = 4'd6,
        PH_CR    = 4'd7,
        PH_TAIL  = 4'd8
    } t_phase;

    typedef struct packed {
        logic emit;
        logic last;
    } t_parse_res;

endpackage

// ===== hw/rtl/ipd_frame_deframer.sv =====
// The deframer takes one received byte per transaction on the slave side and
// passes on the payload of every "+IPD,<length>:" frame on the master side, with
// tlast on the final payload byte. It sustains one byte per clock cycle while the
// master side accepts: each byte is held in an input register, parsed by the header
// state machine and written to an output register, from which a payload byte is
// offered on the master side. A payload byte that cannot move into a full output
// register holds the input register and stalls the slave side.
// Header, trailer and stray bytes produce no transaction.
// Top level; depends on ipdfd_pkg, ipdfd_parser and the assertion header.
`include "ipd_frame_deframer_defines.svh"

module ipd_frame_deframer #(
    parameter int unsigned LEN_BITS = ipdfd_pkg::LEN_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] rx_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] payload_byte
    output logic       o_m_tlast
);

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_last;
    logic                  w_adv;
    ipdfd_pkg::t_parse_res w_res;

    ipdfd_parser #(
        .LEN_BITS (LEN_BITS)
    ) u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    assign w_adv      = r_in_valid && (!w_res.emit || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_adv;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_byte <= i_s_tdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.emit) begin
            r_out_byte <= r_in_byte;
            r_out_last <= w_res.last;
        end
    end

    `IPDFD_ASSERT_SAME(a_stall_only_when_full, i_clk, i_rst_n, !o_s_tready, r_in_valid)
    `IPDFD_ASSERT_SAME(a_free_output_advances, i_clk, i_rst_n,
                       r_in_valid && !r_out_valid, w_adv)
    `IPDFD_ASSERT_NEXT(a_emit_fills_output, i_clk, i_rst_n, w_adv && w_res.emit, r_out_valid)

endmodule

// ===== hw/rtl/ipdfd_parser.sv =====
// Header parser state machine and length counter of the frame deframer.
// Depends on ipdfd_pkg; instantiated by ipd_frame_deframer.
module ipdfd_parser #(
    parameter int unsigned LEN_BITS = ipdfd_pkg::LEN_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    output ipdfd_pkg::t_parse_res o_res
);

    localparam int unsigned ACC_BITS = LEN_BITS + 4;

    ipdfd_pkg::t_phase r_phase;
    ipdfd_pkg::t_phase n_phase;
    logic [LEN_BITS-1:0] r_len;
    logic [LEN_BITS-1:0] n_len;
    logic [3:0]          w_digit;
    logic [ACC_BITS-1:0] w_acc;
    logic                w_is_digit;
    logic                w_last;

    assign w_is_digit = i_byte inside {[ipdfd_pkg::CH_ZERO:ipdfd_pkg::CH_NINE]};
    assign w_digit    = 4'(i_byte - ipdfd_pkg::CH_ZERO);
    assign w_acc      = ({4'b0000, r_len} << 3) + ({4'b0000, r_len} << 1)
                      + {{LEN_BITS{1'b0}}, w_digit};
    assign w_last     = (r_len <= LEN_BITS'(1));

    always_comb begin
        n_phase = ipdfd_pkg::PH_PLUS;
        case (r_phase)
            ipdfd_pkg::PH_PLUS: begin
                if (i_byte == ipdfd_pkg::CH_PLUS) n_phase = ipdfd_pkg::PH_I;
            end
            ipdfd_pkg::PH_I: begin
                if (i_byte == ipdfd_pkg::CH_I) n_phase = ipdfd_pkg::PH_P;
            end
            ipdfd_pkg::PH_P: begin
                if (i_byte == ipdfd_pkg::CH_P) n_phase = ipdfd_pkg::PH_D;
            end
            ipdfd_pkg::PH_D: begin
                if (i_byte == ipdfd_pkg::CH_D) n_phase = ipdfd_pkg::PH_COMMA;
            end
            ipdfd_pkg::PH_COMMA: begin
                if (i_byte == ipdfd_pkg::CH_COMMA) n_phase = ipdfd_pkg::PH_LEN;
            end
            ipdfd_pkg::PH_LEN: begin
                if (w_is_digit) begin
                    n_phase = ipdfd_pkg::PH_LEN;
                end else if (i_byte == ipdfd_pkg::CH_COLON) begin
                    n_phase = ipdfd_pkg::PH_DATA;
                end
            end
            ipdfd_pkg::PH_DATA: begin
                n_phase = w_last ? ipdfd_pkg::PH_CR : ipdfd_pkg::PH_DATA;
            end
            ipdfd_pkg::PH_CR: begin
                if (i_byte == ipdfd_pkg::CH_CR) n_phase = ipdfd_pkg::PH_TAIL;
            end
            default: begin
                n_phase = ipdfd_pkg::PH_PLUS;
            end
        endcase
    end

    always_comb begin
        o_res.emit = 1'b0;
        o_res.last = 1'b0;
        n_len      = r_len;
        case (r_phase)
            ipdfd_pkg::PH_COMMA: begin
                if (i_byte == ipdfd_pkg::CH_COMMA) n_len = '0;
            end
            ipdfd_pkg::PH_LEN: begin
                if (w_is_digit) begin
                    n_len = (|w_acc[ACC_BITS-1:LEN_BITS]) ? {LEN_BITS{1'b1}}
                                                           : w_acc[LEN_BITS-1:0];
                end else if (i_byte != ipdfd_pkg::CH_COLON) begin
                    n_len = '0;
                end
            end
            ipdfd_pkg::PH_DATA: begin
                o_res.emit = 1'b1;
                o_res.last = w_last;
                n_len      = w_last ? '0 : r_len - LEN_BITS'(1);
            end
            default: begin
                n_len = r_len;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= ipdfd_pkg::PH_PLUS;
            r_len   <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_len   <= n_len;
        end
    end

endmodule
